// File: hw/rtl/npcs_pkg.sv
package npcs_pkg;

   // Field widths
   localparam int COMP_W  = 8;
   localparam int INDEX_W = 8;
   localparam int DIST_W  = 18;
   localparam int COUNT_W = 9;
   localparam int ENTRY_W = 3 * COMP_W;

   // Default palette size
   localparam int DEFAULT_PALETTE_DEPTH = 256;

   // Item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_PALETTE_COUNT     = 2'd0;
   localparam logic [1:0] REG_SKIP_TRANSPARENT  = 2'd1;
   localparam logic [1:0] REG_TRANSPARENT_INDEX = 2'd2;

   localparam logic [COUNT_W-1:0] PALETTE_COUNT_RESET = 9'd256;

   // Tag that travels with each palette read through the distance pipe
   typedef struct packed {
      logic               examine;
      logic               last;
      logic [INDEX_W-1:0] idx;
   } scan_tag_type;

endpackage

// File: hw/rtl/npcs_palette_mem.sv
module npcs_palette_mem
   import npcs_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_PALETTE_DEPTH,
   parameter int ADDR_W = $clog2(DEFAULT_PALETTE_DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/npcs_dist_unit.sv
module npcs_dist_unit
   import npcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  scan_tag_type       in_tag,
   input  logic [COMP_W-1:0]  query_red,
   input  logic [COMP_W-1:0]  query_green,
   input  logic [COMP_W-1:0]  query_blue,
   input  logic [ENTRY_W-1:0] entry,
   output logic               out_valid,
   output scan_tag_type       out_tag,
   output logic [DIST_W-1:0]  out_dist
);

   logic [COMP_W-1:0]   ent_r, ent_g, ent_b;
   logic [COMP_W-1:0]   diff_r, diff_g, diff_b;
   logic [2*COMP_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic [2*COMP_W-1:0] sq_r_in, sq_g_in, sq_b_in;
   logic                va_ff, vb_ff;
   scan_tag_type        tag_a_ff, tag_b_ff;
   logic [DIST_W-1:0]   dist_ff, dist_in;

   assign ent_r = entry[3*COMP_W-1:2*COMP_W];
   assign ent_g = entry[2*COMP_W-1:COMP_W];
   assign ent_b = entry[COMP_W-1:0];

   // Take absolute differences and square them
   always_comb begin
      diff_r  = (query_red > ent_r) ? (query_red - ent_r) : (ent_r - query_red);
      diff_g  = (query_green > ent_g) ? (query_green - ent_g) : (ent_g - query_green);
      diff_b  = (query_blue > ent_b) ? (query_blue - ent_b) : (ent_b - query_blue);
      sq_r_in = diff_r * diff_r;
      sq_g_in = diff_g * diff_g;
      sq_b_in = diff_b * diff_b;
   end

   // Sum the squares
   assign dist_in = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // Advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      sq_r_ff  <= sq_r_in;
      sq_g_ff  <= sq_g_in;
      sq_b_ff  <= sq_b_in;
      tag_a_ff <= in_tag;
      dist_ff  <= dist_in;
      tag_b_ff <= tag_a_ff;
   end

   assign out_valid = vb_ff;
   assign out_tag   = tag_b_ff;
   assign out_dist  = dist_ff;

endmodule

// File: hw/rtl/nearest_palette_color_search.sv
// Nearest palette color search. The block holds a palette of PALETTE_DEPTH
// RGB entries in a memory with a write port and a read port. A write item
// stores one entry and is acknowledged in the cycle after it is taken. A
// query item scans entries 0 up to min(palette_count, PALETTE_DEPTH)-1, one
// memory read per cycle through a three-stage distance pipeline, and answers
// with the lowest index of least squared distance; the block takes no new
// item until its answer is loaded into the result register. Writes to
// entries at or above PALETTE_DEPTH are acknowledged and dropped. Reading a
// palette entry that was never written gives an undefined answer.
module nearest_palette_color_search
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   // Result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_is_query_result,
   output logic [INDEX_W-1:0]    rsp_best_index,
   output logic [DIST_W-1:0]     rsp_best_distance,
   output logic                  rsp_no_entry,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);
   localparam int CNT_W  = (ADDR_W > COUNT_W) ? ADDR_W : COUNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;

   // Registers
   logic [COUNT_W-1:0] palette_count_ff;
   logic               skip_transparent_ff;
   logic [INDEX_W-1:0] transparent_index_ff;
   logic               csr_wr;
   logic [1:0]         csr_idx;

   // Query context
   logic [COMP_W-1:0]  q_red_ff, q_green_ff, q_blue_ff;
   logic [COUNT_W-1:0] lim_ff, lim_in;
   logic               skip_en_ff;
   logic [INDEX_W-1:0] skip_idx_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Scan pipe
   logic               issue;
   logic               issue_last;
   scan_tag_type       issue_tag;
   logic               rd_valid_ff;
   scan_tag_type       rd_tag_ff;
   logic [ENTRY_W-1:0] rd_data;
   logic               d_valid;
   scan_tag_type       d_tag;
   logic [DIST_W-1:0]  d_dist;

   // Best so far
   logic               found_ff;
   logic [INDEX_W-1:0] best_idx_ff;
   logic [DIST_W-1:0]  best_dist_ff;

   // Result register
   logic               rsp_valid_ff;
   logic               rsp_query_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_none_ff;
   logic               slot_free;

   logic               req_take;
   logic               wr_take;
   logic               wr_in_range;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_count_ff     <= PALETTE_COUNT_RESET;
         skip_transparent_ff  <= 1'b0;
         transparent_index_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PALETTE_COUNT:     palette_count_ff     <= csr_pwdata[COUNT_W-1:0];
            REG_SKIP_TRANSPARENT:  skip_transparent_ff  <= csr_pwdata[0];
            REG_TRANSPARENT_INDEX: transparent_index_ff <= csr_pwdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PALETTE_COUNT:     csr_prdata = 32'(palette_count_ff);
         REG_SKIP_TRANSPARENT:  csr_prdata = 32'(skip_transparent_ff);
         REG_TRANSPARENT_INDEX: csr_prdata = 32'(transparent_index_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Accept items only while idle and the result slot can take one
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE) && slot_free;
   assign req_take    = req_valid && req_ready;
   assign wr_take     = req_take && (req_opcode == OP_WRITE);
   assign wr_in_range = (32'(req_entry_index) < PALETTE_DEPTH);

   // Clamp the scan length to the palette size
   assign lim_in = (32'(palette_count_ff) > PALETTE_DEPTH) ?
                   COUNT_W'(PALETTE_DEPTH) : palette_count_ff;

   // Issue one palette read per cycle while scanning
   assign issue      = (state_ff == ST_SCAN);
   assign issue_last = (cnt_ff == (CNT_W'(lim_ff) - CNT_W'(1)));
   assign issue_tag.examine = !(skip_en_ff && (cnt_ff == CNT_W'(skip_idx_ff)));
   assign issue_tag.last    = issue_last;
   assign issue_tag.idx     = cnt_ff[INDEX_W-1:0];

   npcs_palette_mem #(
      .DEPTH  (PALETTE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_take && wr_in_range),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (issue),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Align the tag with the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff <= issue_tag;
   end

   npcs_dist_unit u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rd_valid_ff),
      .in_tag      (rd_tag_ff),
      .query_red   (q_red_ff),
      .query_green (q_green_ff),
      .query_blue  (q_blue_ff),
      .entry       (rd_data),
      .out_valid   (d_valid),
      .out_tag     (d_tag),
      .out_dist    (d_dist)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_take && (req_opcode == OP_QUERY)) begin
               state_in = (lim_in == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (issue_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (d_valid && d_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Hold the query context
   always_ff @(posedge clock) begin
      if (req_take) begin
         q_red_ff    <= req_red;
         q_green_ff  <= req_green;
         q_blue_ff   <= req_blue;
         lim_ff      <= lim_in;
         skip_en_ff  <= skip_transparent_ff;
         skip_idx_ff <= transparent_index_ff;
      end
   end

   // Keep the nearest entry; strict less keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_take) begin
         found_ff <= 1'b0;
      end else if (d_valid && d_tag.examine) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid && d_tag.examine && (!found_ff || (d_dist < best_dist_ff))) begin
         best_idx_ff  <= d_tag.idx;
         best_dist_ff <= d_dist;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wr_take || ((state_ff == ST_DONE) && slot_free)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_take) begin
         rsp_query_ff <= 1'b0;
         rsp_idx_ff   <= '0;
         rsp_dist_ff  <= '0;
         rsp_none_ff  <= 1'b0;
      end else if ((state_ff == ST_DONE) && slot_free) begin
         rsp_query_ff <= 1'b1;
         rsp_idx_ff   <= found_ff ? best_idx_ff : '0;
         rsp_dist_ff  <= found_ff ? best_dist_ff : '0;
         rsp_none_ff  <= !found_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_query_result = rsp_query_ff;
   assign rsp_best_index      = rsp_idx_ff;
   assign rsp_best_distance   = rsp_dist_ff;
   assign rsp_no_entry        = rsp_none_ff;

endmodule

// File: tb/sv/palette_search_checker.sv
`timescale 1ns / 100ps

module palette_search_checker
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [COMP_W-1:0]     req_red,
   input  logic [COMP_W-1:0]     req_green,
   input  logic [COMP_W-1:0]     req_blue,
   // Result items
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_is_query_result,
   input  logic [INDEX_W-1:0]    rsp_best_index,
   input  logic [DIST_W-1:0]     rsp_best_distance,
   input  logic                  rsp_no_entry,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   // Status for the testbench top
   output int                    fail_count,
   output int                    pending_count,
   output int                    empty_seen
);

   typedef struct packed {
      logic               is_query;
      logic [INDEX_W-1:0] best_idx;
      logic [DIST_W-1:0]  best_dist;
      logic               empty;
   } palette_answer_type;

   palette_answer_type pending_answers [$];

   // Shadow of the palette and the search registers
   logic [ENTRY_W-1:0] color_mem [PALETTE_DEPTH];
   logic [COUNT_W-1:0] scan_count;
   logic               skip_en;
   logic [INDEX_W-1:0] skip_idx;

   // Scan the active part of the palette for the closest color
   function automatic palette_answer_type nearest_entry(logic [COMP_W-1:0] r,
                                                        logic [COMP_W-1:0] g,
                                                        logic [COMP_W-1:0] b);
      palette_answer_type ans;
      int                 lim;
      int                 d;
      int                 dr;
      int                 dg;
      int                 db;
      int                 best;
      bit                 found;
      logic [ENTRY_W-1:0] e;
      ans = '0;
      ans.is_query = 1'b1;
      found = 1'b0;
      best = 0;
      lim = (scan_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(scan_count);
      for (int n = 0; n < lim; n++) begin
         if (skip_en && n == skip_idx)
            continue;
         e = color_mem[n];
         dr = int'(r) - int'(e[3*COMP_W-1:2*COMP_W]);
         dg = int'(g) - int'(e[2*COMP_W-1:COMP_W]);
         db = int'(b) - int'(e[COMP_W-1:0]);
         d = dr * dr + dg * dg + db * db;
         // strict compare keeps the lowest index on ties
         if (!found || d < best) begin
            best = d;
            ans.best_idx = INDEX_W'(n);
            found = 1'b1;
         end
      end
      ans.best_dist = found ? DIST_W'(best) : '0;
      ans.empty = !found;
      return ans;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      palette_answer_type want;
      palette_answer_type got;
      if (reset) begin
         pending_answers.delete();
         scan_count = PALETTE_COUNT_RESET;
         skip_en = 1'b0;
         skip_idx = '0;
         for (int n = 0; n < PALETTE_DEPTH; n++)
            color_mem[n] = '0;
         fail_count = 0;
         empty_seen = 0;
      end else begin
         // Track register writes; unknown indexes leave everything alone
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_PALETTE_COUNT:     scan_count = csr_pwdata[COUNT_W-1:0];
               REG_SKIP_TRANSPARENT:  skip_en = csr_pwdata[0];
               REG_TRANSPARENT_INDEX: skip_idx = csr_pwdata[INDEX_W-1:0];
               default: ;
            endcase
         end

         // Compare each result with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got = {rsp_is_query_result, rsp_best_index, rsp_best_distance, rsp_no_entry};
            if (pending_answers.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing outstanding, expected none, got %h",
                        $time, got);
            end else begin
               want = pending_answers.pop_front();
               check_field("is_query_result", want.is_query, got.is_query);
               check_field("best_index", want.best_idx, got.best_idx);
               check_field("best_distance", want.best_dist, got.best_dist);
               check_field("no_entry", want.empty, got.empty);
               if (want.is_query && want.empty)
                  empty_seen++;
            end
         end

         // Predict the answer for each accepted item
         if (req_valid && req_ready) begin
            if (req_opcode == OP_WRITE) begin
               if (req_entry_index < PALETTE_DEPTH)
                  color_mem[req_entry_index] = {req_red, req_green, req_blue};
               pending_answers.push_back('0);
            end else begin
               pending_answers.push_back(nearest_entry(req_red, req_green, req_blue));
            end
         end
      end
      pending_count = pending_answers.size();
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import npcs_pkg::*;

   localparam int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH;
   localparam int NUM_PHASES    = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 300;
   localparam int CYCLE_LIMIT   = 2_000_000;
   // Index past the last register, must be ignored by the block
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_opcode = OP_WRITE;
   logic [INDEX_W-1:0]    req_entry_index = '0;
   logic [COMP_W-1:0]     req_red = '0;
   logic [COMP_W-1:0]     req_green = '0;
   logic [COMP_W-1:0]     req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_is_query_result;
   logic [INDEX_W-1:0]    rsp_best_index;
   logic [DIST_W-1:0]     rsp_best_distance;
   logic                  rsp_no_entry;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending_count;
   int empty_seen;

   // Stimulus-side view of what has been stored, so queries only scan written entries
   logic [ENTRY_W-1:0] shadow_colors [PALETTE_DEPTH];
   bit                 written [PALETTE_DEPTH];
   int unsigned        cfg_count = PALETTE_COUNT_RESET;
   bit                 cfg_skip = 1'b0;
   logic [INDEX_W-1:0] cfg_tidx = '0;

   int items_sent = 0;
   int queries_sent = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_pending = 1'b0;
   int phase_counts [NUM_PHASES] = '{2, 5, 1, 16, 0, 37, 64, 3, 100, 9, 129, 256, 8, 511,
                                     300, 256};

   nearest_palette_color_search #(.PALETTE_DEPTH(PALETTE_DEPTH)) uut (.*);

   palette_search_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stalls, or one long hold when asked
   initial begin : result_sink
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic int scan_limit();
      return (cfg_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(cfg_count);
   endfunction

   // Count scanned entries not yet written; first gets the lowest one
   function automatic int unwritten_in_scan(output int first);
      int gaps;
      gaps = 0;
      first = -1;
      for (int n = 0; n < scan_limit(); n++) begin
         if (!(cfg_skip && n == cfg_tidx) && !written[n]) begin
            if (first < 0)
               first = n;
            gaps++;
         end
      end
      return gaps;
   endfunction

   // Favor the extremes of a color component
   function automatic logic [COMP_W-1:0] pick_level();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15)
         return '0;
      if (roll < 30)
         return '1;
      return COMP_W'($urandom());
   endfunction

   // Offer one item and hold it until taken; called and returns at a falling edge
   task automatic send_item(logic op, logic [INDEX_W-1:0] idx, logic [COMP_W-1:0] r,
                            logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (op == OP_QUERY)
         queries_sent++;
   endtask

   task automatic store_entry(logic [INDEX_W-1:0] idx, logic [COMP_W-1:0] r,
                              logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
      send_item(OP_WRITE, idx, r, g, b);
      shadow_colors[idx] = {r, g, b};
      written[idx] = 1'b1;
   endtask

   // Leave psel high at return so back-to-back writes need no extra step
   task automatic csr_write(logic [1:0] reg_sel, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // Drain, then load all three registers with junk in the unused bits
   task automatic set_config(int unsigned count, bit skip, logic [INDEX_W-1:0] tidx);
      wait_idle();
      csr_write(REG_PALETTE_COUNT, ($urandom() & ~32'h1FF) | count);
      csr_write(REG_SKIP_TRANSPARENT, ($urandom() & ~32'h1) | 32'(skip));
      csr_write(REG_TRANSPARENT_INDEX, ($urandom() & ~32'hFF) | 32'(tidx));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cfg_count = count;
      cfg_skip = skip;
      cfg_tidx = tidx;
      settings_used++;
   endtask

   // Fill holes in the scan range first, then mix writes and queries
   task automatic random_item();
      int                 first;
      int                 lim;
      int                 gaps;
      int                 src;
      logic [INDEX_W-1:0] idx;
      logic [COMP_W-1:0]  r;
      logic [COMP_W-1:0]  g;
      logic [COMP_W-1:0]  b;
      lim = scan_limit();
      gaps = unwritten_in_scan(first);
      r = pick_level();
      g = pick_level();
      b = pick_level();
      idx = INDEX_W'($urandom_range(255));
      src = $urandom_range(PALETTE_DEPTH - 1);
      if (gaps != 0 || $urandom_range(99) < 40) begin
         if (gaps != 0 && $urandom_range(3) != 0)
            idx = INDEX_W'(first);
         else if (lim > 0 && $urandom_range(9) < 7)
            idx = INDEX_W'($urandom_range(lim - 1));
         // duplicate colors set up ties
         if ($urandom_range(4) == 0 && written[src])
            {r, g, b} = shadow_colors[src];
         store_entry(idx, r, g, b);
      end else begin
         if (lim > 0 && $urandom_range(3) == 0) begin
            src = $urandom_range(lim - 1);
            if (written[src])
               {r, g, b} = shadow_colors[src];
         end
         send_item(OP_QUERY, idx, r, g, b);
      end
   endtask

   initial begin : stimulus
      int                 first;
      int                 gaps;
      int                 lim;
      int                 n_items;
      bit                 skip;
      logic [INDEX_W-1:0] tidx;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty searches, extremes, ties and transparent skipping
      csr_write(REG_UNUSED, $urandom());
      set_config(0, 1'b0, 8'd0);
      send_item(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(OP_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      store_entry(8'd0, 8'hFF, 8'hFF, 8'hFF);
      store_entry(8'd1, 8'd0, 8'd0, 8'd0);
      store_entry(8'd2, 8'd0, 8'd0, 8'd0);
      store_entry(8'd3, 8'h80, 8'h40, 8'h20);
      store_entry(8'hFF, 8'hAA, 8'h55, 8'hAA);
      set_config(1, 1'b1, 8'd0);
      send_item(OP_QUERY, 8'h0F, 8'd12, 8'd34, 8'd56);
      set_config(1, 1'b0, 8'd0);
      send_item(OP_QUERY, 8'hF0, 8'd0, 8'd0, 8'd0);
      set_config(4, 1'b0, 8'd0);
      send_item(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(OP_QUERY, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_QUERY, 8'd0, 8'h80, 8'h40, 8'h21);
      send_item(OP_QUERY, 8'd0, 8'hFF, 8'd0, 8'd0);
      set_config(4, 1'b1, 8'd1);
      send_item(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(OP_QUERY, 8'd0, 8'd1, 8'd1, 8'd1);
      set_config(3, 1'b1, 8'd2);
      send_item(OP_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);

      // Random phases, each with its own register setting and idle mix
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         lim = (phase_counts[ph] > PALETTE_DEPTH) ? PALETTE_DEPTH : phase_counts[ph];
         skip = $urandom_range(1);
         case ($urandom_range(9))
            0, 1:    tidx = '0;
            2:       tidx = '1;
            default: tidx = (lim > 0) ? INDEX_W'($urandom_range(lim - 1))
                                      : INDEX_W'($urandom_range(255));
         endcase
         if (ph == NUM_PHASES - 1) begin
            skip = 1'b1;
            tidx = '1;
         end
         set_config(phase_counts[ph], skip, tidx);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 83;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 83;
            end
            default: begin
               send_idle_pct = 19;
               rsp_stall_pct = 19;
            end
         endcase
         // block results for a long stretch so the input backs up
         if (ph == 3)
            hold_pending = 1'b1;
         gaps = unwritten_in_scan(first);
         n_items = ((phase_counts[ph] >= PALETTE_DEPTH) ? 40 : 115) + gaps;
         repeat (n_items) random_item();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d items, %0d of them queries (%0d found nothing to search), %0d settings",
               items_sent, queries_sent, empty_seen, settings_used);
      $display("Counts 0 to 511, skip on and off, idle/stall mixes and a %0d-cycle result hold",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_palette_mem.sv
hw/rtl/npcs_dist_unit.sv
hw/rtl/nearest_palette_color_search.sv
tb/sv/palette_search_checker.sv
tb/sv/tb.sv
